### rtl/core/srm_pkg.sv
// Shared types and constants for the step response metrics block.
// No dependencies; imported by every module of the block.
`default_nettype none
package srm_pkg;

	localparam int TIME_W    = 32;
	localparam int SAMPLE_W  = 16;
	localparam int REF_W     = 15;
	localparam int OV_W      = 16;
	localparam int ERR_W     = 16;
	localparam int QT_W      = 40;
	localparam int MD_A_W    = 41;
	localparam int MD_B_W    = 20;
	localparam int MD_P_W    = 61;
	localparam int XT_W      = 62;
	localparam int ADDR_W    = 3;
	localparam int DATA_W    = 32;

	localparam logic [REF_W-1:0] REF_RESET = 15'd4096;

	// register index codes, taken from paddr[2]
	localparam logic REG_REFERENCE = 1'b0;
	localparam logic REG_BAND      = 1'b1;

	// final computation jobs
	typedef enum logic [2:0] {
		JOB_OV = 3'b001,
		JOB_HI = 3'b010,
		JOB_LO = 3'b100
	} job_t;

	typedef struct packed {
		logic accept;
		logic start;
		job_t job;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic job_needed;
		logic done;
	} status_t;

endpackage
`default_nettype wire

### rtl/core/srm_muldiv.sv
// Sequential floor(a*b/c) unit: shift-add multiply, then restoring divide.
// Uses srm_pkg. Result saturates at 2^60.
`default_nettype none
module srm_muldiv
	import srm_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [MD_A_W-1:0] a,
	input  wire logic [MD_B_W-1:0] b,
	input  wire logic [MD_B_W-1:0] c,
	output logic                   done,
	output logic [MD_P_W-1:0]      q
);

	logic              mul_q, div_q, done_q;
	logic [5:0]        cnt_q;
	logic [MD_P_W-1:0] acc_q, mcand_q, quo_q;
	logic [MD_B_W-1:0] mplier_q, c_q;
	logic [MD_B_W-1:0] rem_q;
	logic [MD_B_W:0]   rem_n;
	logic              fits;

	// next partial remainder
	assign rem_n = {rem_q, acc_q[MD_P_W-1]};
	assign fits  = rem_n >= {1'b0, c_q};

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mul_q  <= 1'b0;
			div_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				mul_q <= 1'b1;
			end else if (mul_q && cnt_q == 6'd0) begin
				mul_q <= 1'b0;
				div_q <= 1'b1;
			end else if (div_q && cnt_q == 6'd0) begin
				div_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	// datapath: multiply over the bits of b, then one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (start) begin
			mcand_q  <= MD_P_W'(a);
			mplier_q <= b;
			c_q      <= c;
			acc_q    <= '0;
			cnt_q    <= 6'(MD_B_W - 1);
		end else if (mul_q) begin
			if (mplier_q[0]) acc_q <= acc_q + mcand_q;
			mcand_q  <= mcand_q << 1;
			mplier_q <= mplier_q >> 1;
			if (cnt_q == 6'd0) begin
				cnt_q <= 6'(MD_P_W - 1);
				rem_q <= '0;
				quo_q <= '0;
			end else begin
				cnt_q <= cnt_q - 6'd1;
			end
		end else if (div_q) begin
			rem_q <= fits ? MD_B_W'(rem_n - {1'b0, c_q}) : rem_n[MD_B_W-1:0];
			quo_q <= {quo_q[MD_P_W-2:0], fits};
			acc_q <= acc_q << 1;
			cnt_q <= cnt_q - 6'd1;
		end
	end

	assign done = done_q;
	assign q    = quo_q[MD_P_W-1] ? {1'b1, {(MD_P_W-1){1'b0}}} : quo_q;

endmodule
`default_nettype wire

### rtl/core/srm_datapath.sv
// Run tracking (peak, rise brackets, settling band) and final result assembly.
// Uses srm_pkg and srm_muldiv.
`default_nettype none
module srm_datapath
	import srm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire cmd_t                       cmd,
	output status_t                         status,
	input  wire logic [REF_W-1:0]           ref_level,
	input  wire logic                       band_sel,
	input  wire logic [TIME_W-1:0]          sample_time,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	output logic [OV_W-1:0]                 overshoot_pct,
	output logic [TIME_W-1:0]               peak_time,
	output logic [QT_W-1:0]                 rise_time,
	output logic [QT_W-1:0]                 settling_time,
	output logic [ERR_W-1:0]                steady_error,
	output logic                            rise_found,
	output logic                            divide_fault
);

	localparam logic [1:0] RISE_LOW  = 2'd0;
	localparam logic [1:0] RISE_MID  = 2'd1;
	localparam logic [1:0] RISE_DONE = 2'd2;
	localparam logic [QT_W-1:0] QT_MAX = '1;

	// run state
	logic [1:0]                 phase_q, idx_q;
	logic signed [SAMPLE_W-1:0] peak_q, pv_q;
	logic [TIME_W-1:0]          pstamp_q, pt_q;
	logic [TIME_W-1:0]          lt_q [2];
	logic signed [SAMPLE_W-1:0] lv_q [2];
	logic [TIME_W-1:0]          ht_q [2];
	logic signed [SAMPLE_W-1:0] hv_q [2];
	logic [TIME_W-1:0]          ot_q [2];
	logic                       la_q, ha_q, op_q;
	logic [OV_W-1:0]            ov_q;
	logic signed [XT_W-1:0]     t90_q, t10_q;

	// per-sample level tests
	logic signed [16:0] yr;
	logic signed [19:0] y10, yr1, yr9;
	logic signed [17:0] ey;
	logic [16:0]        emag;
	logic               first, lt10, lt90, outb, la, ha;
	logic [1:0]         phase_n;

	assign yr    = $signed({2'b00, ref_level});
	assign y10   = 20'(sample_value) * 20'sd10;
	assign yr1   = 20'(yr);
	assign yr9   = 20'(yr) * 20'sd9;
	assign lt10  = y10 <= yr1;
	assign lt90  = y10 <= yr9;
	assign ey    = 18'(yr) - 18'(sample_value);
	assign emag  = ey[17] ? 17'(-ey) : ey[16:0];
	assign first = idx_q == 2'd0;
	assign outb  = ((24'(emag) * 24'd100) >
		(24'(ref_level) * (band_sel ? 24'd5 : 24'd2))) || first;

	// rise tracker
	always_comb begin
		la      = first;
		ha      = first;
		phase_n = phase_q;
		case (phase_q)
			RISE_LOW: begin
				if (lt10) la = 1'b1;
				else phase_n = RISE_MID;
			end
			RISE_MID: begin
				if (lt90) ha = 1'b1;
				else phase_n = RISE_DONE;
			end
			default: ;
		endcase
	end

	// crossing operands for the selected bracket
	logic [TIME_W-1:0]          ta, tb;
	logic signed [SAMPLE_W-1:0] ya, yb;
	logic signed [19:0]         kyr;
	logic signed [16:0]         dy;
	logic signed [20:0]         den, num;
	logic [MD_B_W-1:0]          denmag, nummag;
	logic signed [TIME_W:0]     dt;
	logic [TIME_W:0]            dtmag;
	logic                       neg, peak_ge, ref_zero, hi_zero, lo_zero, phase_done;
	logic signed [16:0]         ovdiff;

	always_comb begin
		if (cmd.job == JOB_HI) begin
			ta = ht_q[0]; ya = hv_q[0]; tb = ht_q[1]; yb = hv_q[1]; kyr = yr9;
		end else begin
			ta = lt_q[0]; ya = lv_q[0]; tb = lt_q[1]; yb = lv_q[1]; kyr = yr1;
		end
	end

	assign dy     = 17'(yb) - 17'(ya);
	assign den    = 21'(dy) * 21'sd10;
	assign num    = 21'(yb) * 21'sd10 - 21'(kyr);
	assign denmag = den[20] ? MD_B_W'(-den) : den[MD_B_W-1:0];
	assign nummag = num[20] ? MD_B_W'(-num) : num[MD_B_W-1:0];
	assign dt     = $signed({1'b0, tb}) - $signed({1'b0, ta});
	assign dtmag  = dt[TIME_W] ? (TIME_W+1)'(-dt) : dt;
	assign neg    = dt[TIME_W] ^ num[20] ^ den[20];

	assign peak_ge    = 17'(peak_q) >= yr;
	assign ref_zero   = ref_level == '0;
	assign hi_zero    = hv_q[1] == hv_q[0];
	assign lo_zero    = lv_q[1] == lv_q[0];
	assign phase_done = phase_q == RISE_DONE;
	assign ovdiff     = 17'(peak_q) - yr;

	// shared multiply-divide unit
	logic [MD_A_W-1:0] md_a;
	logic [MD_B_W-1:0] md_b, md_c;
	logic [MD_P_W-1:0] md_q;
	logic              md_done;

	always_comb begin
		if (cmd.job == JOB_OV) begin
			md_a = MD_A_W'(ovdiff[15:0]);
			md_b = 20'd25600;
			md_c = MD_B_W'(ref_level);
		end else begin
			md_a = {dtmag, 8'b0};
			md_b = nummag;
			md_c = denmag;
		end
	end

	srm_muldiv u_muldiv (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.start),
		.a      (md_a),
		.b      (md_b),
		.c      (md_c),
		.done   (md_done),
		.q      (md_q)
	);

	// crossing time from the quotient
	logic signed [XT_W-1:0] base, qx, xt;
	assign base = $signed({22'b0, tb, 8'b0});
	assign qx   = $signed({1'b0, md_q});
	assign xt   = neg ? base + qx : base - qx;

	always_comb begin
		status.done = md_done;
		case (cmd.job)
			JOB_OV:  status.job_needed = peak_ge && !ref_zero;
			JOB_HI:  status.job_needed = phase_done && !hi_zero;
			JOB_LO:  status.job_needed = phase_done && !lo_zero;
			default: status.job_needed = 1'b0;
		endcase
	end

	// result assembly
	logic signed [XT_W:0]   rd;
	logic                   rise_fault, ov_fault;
	logic [QT_W-1:0]        rt, st, last_q;
	logic [TIME_W:0]        osum;
	logic signed [17:0]     el;
	logic [16:0]            elmag;
	logic [OV_W-1:0]        ov;

	assign rd         = 63'(t90_q) - 63'(t10_q);
	assign rise_fault = phase_done && (hi_zero || lo_zero);
	assign ov_fault   = peak_ge && ref_zero && (peak_q > 0);
	assign last_q     = {pt_q, 8'b0};
	assign osum       = {1'b0, ot_q[0]} + {1'b0, ot_q[1]};
	assign st         = op_q ? last_q : {osum, 7'b0};
	assign el         = 18'(yr) - 18'(pv_q);
	assign elmag      = el[17] ? 17'(-el) : el[16:0];

	always_comb begin
		if (!phase_done) rt = last_q;
		else if (rise_fault) rt = QT_MAX;
		else if (rd[XT_W]) rt = '0;
		else if (|rd[XT_W-1:QT_W]) rt = QT_MAX;
		else rt = rd[QT_W-1:0];
		if (!peak_ge) ov = '0;
		else if (ref_zero) ov = ov_fault ? '1 : '0;
		else ov = ov_q;
	end

	// capture job results
	always_ff @(posedge clk) begin
		if (md_done) begin
			case (cmd.job)
				JOB_OV:  ov_q  <= (|md_q[MD_P_W-1:OV_W]) ? '1 : md_q[OV_W-1:0];
				JOB_HI:  t90_q <= xt;
				default: t10_q <= xt;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			overshoot_pct <= ov;
			peak_time     <= peak_ge ? pstamp_q : '0;
			rise_time     <= rt;
			settling_time <= st;
			steady_error  <= elmag[16] ? '1 : elmag[15:0];
			rise_found    <= phase_done;
			divide_fault  <= ov_fault || rise_fault;
		end
	end

	// run state update per sample, cleared as the result is loaded into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= RISE_LOW;
			idx_q    <= '0;
			peak_q   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			pstamp_q <= '0;
			pt_q     <= '0;
			pv_q     <= '0;
			lt_q     <= '{default: '0};
			lv_q     <= '{default: '0};
			ht_q     <= '{default: '0};
			hv_q     <= '{default: '0};
			ot_q     <= '{default: '0};
			la_q     <= 1'b0;
			ha_q     <= 1'b0;
			op_q     <= 1'b0;
		end else if (cmd.finish) begin
			phase_q  <= RISE_LOW;
			idx_q    <= '0;
			peak_q   <= {1'b1, {(SAMPLE_W-1){1'b0}}};
			pstamp_q <= '0;
			pt_q     <= '0;
			pv_q     <= '0;
			lt_q     <= '{default: '0};
			lv_q     <= '{default: '0};
			ht_q     <= '{default: '0};
			hv_q     <= '{default: '0};
			ot_q     <= '{default: '0};
			la_q     <= 1'b0;
			ha_q     <= 1'b0;
			op_q     <= 1'b0;
		end else if (cmd.accept) begin
			// close the brackets opened by the previous sample
			if (!first && la_q) begin lt_q[1] <= sample_time; lv_q[1] <= sample_value; end
			if (!first && ha_q) begin ht_q[1] <= sample_time; hv_q[1] <= sample_value; end
			if (!first && op_q) ot_q[1] <= sample_time;
			if (first || sample_value > peak_q) begin
				peak_q   <= sample_value;
				pstamp_q <= sample_time;
			end
			if (la) begin lt_q[0] <= sample_time; lv_q[0] <= sample_value; end
			if (ha) begin ht_q[0] <= sample_time; hv_q[0] <= sample_value; end
			if (outb) ot_q[0] <= sample_time;
			phase_q <= phase_n;
			la_q    <= la;
			ha_q    <= ha;
			op_q    <= outb;
			pt_q    <= sample_time;
			pv_q    <= sample_value;
			if (idx_q != 2'd2) idx_q <= idx_q + 2'd1;
		end
	end

endmodule
`default_nettype wire

### rtl/core/srm_ctrl.sv
// Controller: request handshakes and the sequence of final jobs.
// Uses srm_pkg; drives the datapath through cmd_t, reads status_t.
`default_nettype none
module srm_ctrl
	import srm_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    last_sample,
	output logic         in_ready,
	output logic         out_valid,
	input  wire logic    out_ready,
	input  wire status_t status,
	output cmd_t         cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_START  = 4'b0010,
		ST_WAIT   = 4'b0100,
		ST_FINISH = 4'b1000
	} state_t;

	state_t state_q, state_n;
	job_t   job_q, job_n, job_next;
	logic   out_valid_q;

	always_comb begin
		case (job_q)
			JOB_OV:  job_next = JOB_HI;
			default: job_next = JOB_LO;
		endcase
	end

	// next state and commands
	always_comb begin
		state_n    = state_q;
		job_n      = job_q;
		cmd.accept = 1'b0;
		cmd.start  = 1'b0;
		cmd.finish = 1'b0;
		cmd.job    = job_q;
		case (state_q)
			ST_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && last_sample) begin
					state_n = ST_START;
					job_n   = JOB_OV;
				end
			end
			ST_START: begin
				if (status.job_needed) begin
					cmd.start = 1'b1;
					state_n   = ST_WAIT;
				end else if (job_q == JOB_LO) begin
					state_n = ST_FINISH;
				end else begin
					job_n = job_next;
				end
			end
			ST_WAIT: begin
				if (status.done) begin
					if (job_q == JOB_LO) begin
						state_n = ST_FINISH;
					end else begin
						job_n   = job_next;
						state_n = ST_START;
					end
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.finish = 1'b1;
					state_n    = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			job_q       <= JOB_OV;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			job_q   <= job_n;
			if (cmd.finish) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### rtl/core/step_response_metrics.sv
// Step response metrics, top level. A sample other than the last is taken into the run
// state as it is accepted. The last sample starts up to three multiply-divide jobs on one
// shared unit, each of 20 multiply steps and 61 quotient bits; the result of the run then
// waits in an output register.
// arst_n clears the run state and loads reference 4096 and the 2 percent band.
`default_nettype none
module step_response_metrics
	import srm_pkg::*;
(
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [ADDR_W-1:0]          paddr,
	input  wire logic [DATA_W-1:0]          pwdata,
	output logic [DATA_W-1:0]               prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [TIME_W-1:0]          sample_time,
	input  wire logic signed [SAMPLE_W-1:0] sample_value,
	input  wire logic                       last_sample,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic [OV_W-1:0]                 overshoot_pct,
	output logic [TIME_W-1:0]               peak_time,
	output logic [QT_W-1:0]                 rise_time,
	output logic [QT_W-1:0]                 settling_time,
	output logic [ERR_W-1:0]                steady_error,
	output logic                            rise_found,
	output logic                            divide_fault
);

	logic [REF_W-1:0] ref_level_q;
	logic             band_sel_q;
	cmd_t             cmd;
	status_t          status;

	// configuration registers
	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ref_level_q <= REF_RESET;
			band_sel_q  <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_REFERENCE: ref_level_q <= pwdata[REF_W-1:0];
				REG_BAND:      band_sel_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_REFERENCE: prdata = DATA_W'(ref_level_q);
			REG_BAND:      prdata = DATA_W'(band_sel_q);
			default:       prdata = '0;
		endcase
	end

	srm_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.last_sample (last_sample),
		.in_ready    (in_ready),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.status      (status),
		.cmd         (cmd)
	);

	srm_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.ref_level     (ref_level_q),
		.band_sel      (band_sel_q),
		.sample_time   (sample_time),
		.sample_value  (sample_value),
		.overshoot_pct (overshoot_pct),
		.peak_time     (peak_time),
		.rise_time     (rise_time),
		.settling_time (settling_time),
		.steady_error  (steady_error),
		.rise_found    (rise_found),
		.divide_fault  (divide_fault)
	);

	// a last request closes the input until its result is loaded into the output register
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && last_sample) |=> !in_ready)
		else $error("input open after last request");

	// jobs start only while inputs are held off
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |-> !in_ready)
		else $error("job started while accepting requests");

	// a finished run always presents a result
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid)
		else $error("finished run without result");

endmodule
`default_nettype wire
